@@ hw/rtl/bfsa_pkg.sv @@
// Shared constants and codes of the best-fit span allocator.
`default_nettype none
package bfsa_pkg;
  localparam int MAX_HOLES = 64;
  localparam int IDX_W     = $clog2(MAX_HOLES);
  localparam int CNT_W     = $clog2(MAX_HOLES + 1);
  localparam int ENTRY_W   = 64;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_NO_ROOM   = 2'd2;
  localparam logic [1:0] ST_BAD_REL   = 2'd3;

  typedef logic [ENTRY_W-1:0] entry_t;
endpackage
`default_nettype wire

@@ hw/rtl/bfsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/best_fit_span_allocator_top.sv @@
// Best-fit span allocator: sorted hole table in RAM, end mark, block boundary register.
// Clear, op 3 and rejected requests go straight to the result. Allocate reads each hole, takes a
// bit-serial remainder per candidate hole (none with no block size) and, when no hole fits, at the
// end mark. Release reads holes up to the span. Table writes follow, shifting entries for a slot.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset (synchronous, rst_n low): empty table, end mark 0, block size 0, no result pending.
`default_nettype none
module best_fit_span_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_req_offset,
  input  wire logic [31:0] in_req_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_grant_offset,
  output logic [31:0]      out_grant_count,
  output logic [31:0]      out_free_total,
  output logic [31:0]      out_end_mark,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_block_size
);
  import bfsa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_A_EVAL = 4'd5;
  localparam logic [3:0] S_A_FIN  = 4'd6;
  localparam logic [3:0] S_E_EVAL = 4'd7;
  localparam logic [3:0] S_R_RD   = 4'd8;
  localparam logic [3:0] S_R_CHK  = 4'd9;
  localparam logic [3:0] S_R_DEC  = 4'd10;
  localparam logic [3:0] S_SH_RD  = 4'd11;
  localparam logic [3:0] S_SH_WR  = 4'd12;
  localparam logic [3:0] S_W1     = 4'd13;
  localparam logic [3:0] S_W2     = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HOLES);

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      off_r, off_nxt, cnt_r, cnt_nxt;
  logic [31:0]      bsize_r, bsize_nxt;
  logic [CNT_W-1:0] total_r, total_nxt, idx_r, idx_nxt;
  logic [31:0]      used_r, used_nxt, free_r, free_nxt;
  logic [31:0]      ent_s_r, ent_s_nxt, ent_l_r, ent_l_nxt;
  logic [31:0]      rem_r, rem_nxt, dq_r, dq_nxt;
  logic [4:0]       dcnt_r, dcnt_nxt;
  logic             dret_r, dret_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [32:0]      best_at_r, best_at_nxt;
  logic [31:0]      best_s_r, best_s_nxt, best_l_r, best_l_nxt;
  logic [31:0]      prev_s_r, prev_s_nxt, prev_l_r, prev_l_nxt;
  logic             hp_r, hp_nxt, hn_r, hn_nxt;
  logic             sh_up_r, sh_up_nxt;
  logic [CNT_W-1:0] sh_j_r, sh_j_nxt, sh_k_r, sh_k_nxt;
  logic             wa_v_r, wa_v_nxt, wb_v_r, wb_v_nxt;
  logic [IDX_W-1:0] wa_addr_r, wa_addr_nxt, wb_addr_r, wb_addr_nxt;
  entry_t           wa_data_r, wa_data_nxt, wb_data_r, wb_data_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic [31:0]      res_goff_r, res_goff_nxt, res_gcnt_r, res_gcnt_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       ost_r, ost_nxt;
  logic [31:0]      ogoff_r, ogoff_nxt, ogcnt_r, ogcnt_nxt;
  logic [31:0]      ofree_r, ofree_nxt, oend_r, oend_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic        ev_push, ev_fit;
  logic [32:0] ev_at;
  logic [32:0] dt;
  logic [31:0] fb_before, fb_after;
  logic [32:0] fb_run_end;
  logic [32:0] span_end, prev_end, next_end, m_end;
  logic [31:0] m_start;
  logic        jn, jp, gb, rel_bad;
  logic        sh_done;
  logic [31:0] rd_s, rd_l;

  bfsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_HOLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_s = ram_rdata[63:32];
  assign rd_l = ram_rdata[31:0];

  // boundary check of the current entry: push to next boundary if the run would cross it
  assign ev_push = (bsize_r != 32'd0) &&
                   (({2'b0, rem_r} + {2'b0, cnt_r} - 34'd1) >= {2'b0, bsize_r});
  assign ev_at   = ev_push ? ({1'b0, ent_s_r} - {1'b0, rem_r} + {1'b0, bsize_r})
                           : {1'b0, ent_s_r};
  assign ev_fit  = ({1'b0, ev_at} + {2'b0, cnt_r}) <= ({2'b0, ent_s_r} + {2'b0, ent_l_r});
  assign dt      = {rem_r, dq_r[31]};

  assign fb_before  = best_at_r[31:0] - best_s_r;
  assign fb_run_end = best_at_r + {1'b0, cnt_r};
  assign fb_after   = best_s_r + best_l_r - fb_run_end[31:0];

  assign span_end = {1'b0, off_r} + {1'b0, cnt_r};
  assign prev_end = {1'b0, prev_s_r} + {1'b0, prev_l_r};
  assign next_end = {1'b0, ent_s_r} + {1'b0, ent_l_r};
  assign jn       = hn_r && (span_end == {1'b0, ent_s_r});
  assign jp       = hp_r && (prev_end == {1'b0, off_r});
  assign m_start  = jp ? prev_s_r : off_r;
  assign m_end    = jn ? next_end : span_end;
  assign gb       = m_end == {1'b0, used_r};
  assign rel_bad  = (hn_r && (span_end > {1'b0, ent_s_r})) ||
                    (hp_r && (prev_end > {1'b0, off_r}));

  assign sh_done = sh_up_r ? (sh_j_r == sh_k_r)
                           : (({1'b0, sh_j_r} + 1'b1) >= {1'b0, total_r});

  assign in_stall         = state_r != S_IDLE;
  assign cfg_ready        = state_r == S_IDLE;
  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_grant_offset = ogoff_r;
  assign out_grant_count  = ogcnt_r;
  assign out_free_total   = ofree_r;
  assign out_end_mark     = oend_r;

  always_comb begin
    state_nxt = state_r;     op_nxt = op_r;         off_nxt = off_r;
    cnt_nxt = cnt_r;         bsize_nxt = bsize_r;   total_nxt = total_r;
    idx_nxt = idx_r;         used_nxt = used_r;     free_nxt = free_r;
    ent_s_nxt = ent_s_r;     ent_l_nxt = ent_l_r;   rem_nxt = rem_r;
    dq_nxt = dq_r;           dcnt_nxt = dcnt_r;     dret_nxt = dret_r;
    found_nxt = found_r;     best_idx_nxt = best_idx_r;
    best_at_nxt = best_at_r; best_s_nxt = best_s_r; best_l_nxt = best_l_r;
    prev_s_nxt = prev_s_r;   prev_l_nxt = prev_l_r;
    hp_nxt = hp_r;           hn_nxt = hn_r;
    sh_up_nxt = sh_up_r;     sh_j_nxt = sh_j_r;     sh_k_nxt = sh_k_r;
    wa_v_nxt = wa_v_r;       wb_v_nxt = wb_v_r;
    wa_addr_nxt = wa_addr_r; wb_addr_nxt = wb_addr_r;
    wa_data_nxt = wa_data_r; wb_data_nxt = wb_data_r;
    res_st_nxt = res_st_r;   res_goff_nxt = res_goff_r; res_gcnt_nxt = res_gcnt_r;
    ov_nxt = ov_r;           ost_nxt = ost_r;
    ogoff_nxt = ogoff_r;     ogcnt_nxt = ogcnt_r;
    ofree_nxt = ofree_r;     oend_nxt = oend_r;
    ram_we = 1'b0;
    ram_waddr = wa_addr_r;
    ram_wdata = wa_data_r;
    ram_raddr = idx_r[IDX_W-1:0];

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          bsize_nxt = cfg_block_size;
        end
        if (in_valid) begin
          op_nxt    = in_op;
          off_nxt   = in_req_offset;
          cnt_nxt   = in_req_count;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_st_nxt   = ST_OK;
        res_goff_nxt = 32'd0;
        res_gcnt_nxt = 32'd0;
        idx_nxt      = '0;
        found_nxt    = 1'b0;
        hp_nxt       = 1'b0;
        wa_v_nxt     = 1'b0;
        wb_v_nxt     = 1'b0;
        state_nxt    = S_DONE;
        case (op_r)
          OP_ALLOC: begin
            if (cnt_r == 32'd0 || (bsize_r != 32'd0 && cnt_r > bsize_r)) begin
              res_st_nxt = ST_BAD_COUNT;
            end else if (total_r == '0) begin
              state_nxt = S_A_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end
          OP_RELEASE: begin
            if (cnt_r == 32'd0) begin
              res_st_nxt = ST_OK;
            end else if (span_end > {1'b0, used_r}) begin
              res_st_nxt = ST_BAD_REL;
            end else begin
              state_nxt = S_R_RD;
            end
          end
          OP_CLEAR: begin
            total_nxt = '0;
            used_nxt  = 32'd0;
            free_nxt  = 32'd0;
          end
          default: begin
          end
        endcase
      end
      S_A_RD: begin
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        ent_s_nxt = rd_s;
        ent_l_nxt = rd_l;
        rem_nxt   = 32'd0;
        dq_nxt    = rd_s;
        dcnt_nxt  = '0;
        dret_nxt  = 1'b0;
        // skip holes too short or no better than the current best
        if (rd_l < cnt_r || (found_r && rd_l >= best_l_r)) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ((idx_r + 1'b1) == total_r) ? S_A_FIN : S_A_RD;
        end else begin
          state_nxt = (bsize_r == 32'd0) ? S_A_EVAL : S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = (dt >= {1'b0, bsize_r}) ? 32'(dt - {1'b0, bsize_r}) : dt[31:0];
        dq_nxt   = {dq_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd31) begin
          state_nxt = dret_r ? S_E_EVAL : S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        if (ev_fit) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r[IDX_W-1:0];
          best_at_nxt  = ev_at;
          best_s_nxt   = ent_s_r;
          best_l_nxt   = ent_l_r;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ((idx_r + 1'b1) == total_r) ? S_A_FIN : S_A_RD;
      end
      S_A_FIN: begin
        if (found_r) begin
          if (fb_before != 32'd0 && fb_after != 32'd0 && total_r >= MAX_CNT) begin
            res_st_nxt = ST_NO_ROOM;
            state_nxt  = S_DONE;
          end else begin
            res_goff_nxt = best_at_r[31:0];
            res_gcnt_nxt = cnt_r;
            free_nxt     = free_r - cnt_r;
            if (fb_before == 32'd0) begin
              if (fb_after != 32'd0) begin
                wa_v_nxt    = 1'b1;
                wa_addr_nxt = best_idx_r;
                wa_data_nxt = {fb_run_end[31:0], fb_after};
                state_nxt   = S_W1;
              end else begin
                sh_up_nxt = 1'b0;
                sh_j_nxt  = {1'b0, best_idx_r};
                state_nxt = S_SH_RD;
              end
            end else if (fb_after == 32'd0) begin
              wa_v_nxt    = 1'b1;
              wa_addr_nxt = best_idx_r;
              wa_data_nxt = {best_s_r, fb_before};
              state_nxt   = S_W1;
            end else begin
              // open a slot after the best hole, then write both leftovers
              wa_v_nxt    = 1'b1;
              wa_addr_nxt = best_idx_r + 1'b1;
              wa_data_nxt = {fb_run_end[31:0], fb_after};
              wb_v_nxt    = 1'b1;
              wb_addr_nxt = best_idx_r;
              wb_data_nxt = {best_s_r, fb_before};
              sh_up_nxt   = 1'b1;
              sh_j_nxt    = total_r;
              sh_k_nxt    = {1'b0, best_idx_r} + 1'b1;
              state_nxt   = S_SH_RD;
            end
          end
        end else begin
          ent_s_nxt = used_r;
          ent_l_nxt = 32'd0;
          rem_nxt   = 32'd0;
          dq_nxt    = used_r;
          dcnt_nxt  = '0;
          dret_nxt  = 1'b1;
          state_nxt = (bsize_r == 32'd0) ? S_E_EVAL : S_DIV;
        end
      end
      S_E_EVAL: begin
        state_nxt = S_DONE;
        if (({1'b0, ev_at} + {2'b0, cnt_r}) > 34'h0FFFFFFFF ||
            (ev_push && total_r >= MAX_CNT)) begin
          res_st_nxt = ST_NO_ROOM;
        end else begin
          if (ev_push) begin
            wa_v_nxt    = 1'b1;
            wa_addr_nxt = total_r[IDX_W-1:0];
            wa_data_nxt = {used_r, ev_at[31:0] - used_r};
            total_nxt   = total_r + 1'b1;
            free_nxt    = free_r + (ev_at[31:0] - used_r);
            state_nxt   = S_W1;
          end
          used_nxt     = ev_at[31:0] + cnt_r;
          res_goff_nxt = ev_at[31:0];
          res_gcnt_nxt = cnt_r;
        end
      end
      S_R_RD: begin
        hn_nxt = 1'b0;
        state_nxt = (idx_r == total_r) ? S_R_DEC : S_R_CHK;
      end
      S_R_CHK: begin
        if (rd_s < off_r) begin
          prev_s_nxt = rd_s;
          prev_l_nxt = rd_l;
          hp_nxt     = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          state_nxt  = S_R_RD;
        end else begin
          ent_s_nxt = rd_s;
          ent_l_nxt = rd_l;
          hn_nxt    = 1'b1;
          state_nxt = S_R_DEC;
        end
      end
      S_R_DEC: begin
        state_nxt = S_DONE;
        if (rel_bad) begin
          res_st_nxt = ST_BAD_REL;
        end else if (!jn && !jp && !gb && total_r >= MAX_CNT) begin
          res_st_nxt = ST_NO_ROOM;
        end else if (gb) begin
          // merged hole is the last one: hand it back to the end mark
          total_nxt = total_r - {{(CNT_W-1){1'b0}}, jn} - {{(CNT_W-1){1'b0}}, jp};
          used_nxt  = m_start;
          free_nxt  = free_r - (jp ? prev_l_r : 32'd0) - (jn ? ent_l_r : 32'd0);
        end else begin
          free_nxt = free_r + cnt_r;
          wa_v_nxt = 1'b1;
          if (jn && jp) begin
            wa_addr_nxt = IDX_W'(idx_r - 1'b1);
            wa_data_nxt = {prev_s_r, m_end[31:0] - prev_s_r};
            sh_up_nxt   = 1'b0;
            sh_j_nxt    = idx_r;
            state_nxt   = S_SH_RD;
          end else if (jp) begin
            wa_addr_nxt = IDX_W'(idx_r - 1'b1);
            wa_data_nxt = {prev_s_r, prev_l_r + cnt_r};
            state_nxt   = S_W1;
          end else if (jn) begin
            wa_addr_nxt = idx_r[IDX_W-1:0];
            wa_data_nxt = {off_r, cnt_r + ent_l_r};
            state_nxt   = S_W1;
          end else begin
            wa_addr_nxt = idx_r[IDX_W-1:0];
            wa_data_nxt = {off_r, cnt_r};
            sh_up_nxt   = 1'b1;
            sh_j_nxt    = total_r;
            sh_k_nxt    = idx_r;
            state_nxt   = S_SH_RD;
          end
        end
      end
      S_SH_RD: begin
        ram_raddr = sh_up_r ? IDX_W'(sh_j_r - 1'b1) : IDX_W'(sh_j_r + 1'b1);
        if (sh_done) begin
          total_nxt = sh_up_r ? (total_r + 1'b1) : (total_r - 1'b1);
          state_nxt = wa_v_r ? S_W1 : S_DONE;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_j_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        sh_j_nxt  = sh_up_r ? (sh_j_r - 1'b1) : (sh_j_r + 1'b1);
        state_nxt = S_SH_RD;
      end
      S_W1: begin
        ram_we    = 1'b1;
        state_nxt = wb_v_r ? S_W2 : S_DONE;
      end
      S_W2: begin
        ram_we    = 1'b1;
        ram_waddr = wb_addr_r;
        ram_wdata = wb_data_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          ogoff_nxt = res_goff_r;
          ogcnt_nxt = res_gcnt_r;
          ofree_nxt = free_r;
          oend_nxt  = used_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      used_r  <= 32'd0;
      free_r  <= 32'd0;
      bsize_r <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      used_r  <= used_nxt;
      free_r  <= free_nxt;
      bsize_r <= bsize_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;             off_r <= off_nxt;           cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;           ent_s_r <= ent_s_nxt;       ent_l_r <= ent_l_nxt;
    rem_r <= rem_nxt;           dq_r <= dq_nxt;             dcnt_r <= dcnt_nxt;
    dret_r <= dret_nxt;         found_r <= found_nxt;       best_idx_r <= best_idx_nxt;
    best_at_r <= best_at_nxt;   best_s_r <= best_s_nxt;     best_l_r <= best_l_nxt;
    prev_s_r <= prev_s_nxt;     prev_l_r <= prev_l_nxt;     hp_r <= hp_nxt;
    hn_r <= hn_nxt;             sh_up_r <= sh_up_nxt;       sh_j_r <= sh_j_nxt;
    sh_k_r <= sh_k_nxt;         wa_v_r <= wa_v_nxt;         wb_v_r <= wb_v_nxt;
    wa_addr_r <= wa_addr_nxt;   wb_addr_r <= wb_addr_nxt;
    wa_data_r <= wa_data_nxt;   wb_data_r <= wb_data_nxt;
    res_st_r <= res_st_nxt;     res_goff_r <= res_goff_nxt; res_gcnt_r <= res_gcnt_nxt;
    ost_r <= ost_nxt;           ogoff_r <= ogoff_nxt;       ogcnt_r <= ogcnt_nxt;
    ofree_r <= ofree_nxt;       oend_r <= oend_nxt;
  end
endmodule
`default_nettype wire
